// ----- src/sprite_frame_sequencer_defines.svh -----
// Assertion macros for the sprite frame sequencer checker.
// Expects clk and arst_n in the scope of use.
`ifndef SPRITE_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SFS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sprite frame sequencer check failed");

// next-cycle implication
`define SFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sprite frame sequencer check failed");

`endif

// ----- src/sfs_pkg.sv -----
// Shared types and codes for the sprite frame sequencer.
// No dependencies.
`default_nettype none
package sfs_pkg;
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_REGISTER = 3'd1;
	localparam logic [2:0] OP_CREATE   = 3'd2;
	localparam logic [2:0] OP_DESTROY  = 3'd3;
	localparam logic [2:0] OP_QUERY    = 3'd4;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_FULL   = 2'd1;
	localparam logic [1:0] STATUS_UNUSED = 2'd2;

	typedef enum logic [2:0] {RES_NONE, RES_FULL, RES_UNUSED, RES_GRANT, RES_QUERY} res_kind_t;

	typedef struct packed {
		logic [9:0]  texture;
		logic [8:0]  total;
		logic [8:0]  across;
		logic [23:0] period;
		logic [11:0] width;
		logic [11:0] height;
		logic [11:0] org_x;
		logic [11:0] org_y;
		logic        repeats;
	} pattern_t;

	typedef struct packed {
		logic [7:0]  pattern;
		logic [7:0]  frame;
		logic [31:0] acc;
	} player_t;

	typedef struct packed {
		logic      capture;
		logic      idx_clr;
		logic      idx_inc;
		logic      ply_rd_idx;
		logic      ply_rd_slot;
		logic      pat_rd;
		logic      tick_cmp;
		logic      tick_wr;
		logic      pat_claim;
		logic      ply_claim;
		logic      ply_free;
		logic      div_start;
		logic      div_step;
		logic      q_mul;
		logic      emit;
		res_kind_t kind;
	} sfs_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       pat_idx_used;
		logic       ply_idx_used;
		logic       pat_scan_end;
		logic       ply_scan_end;
		logic       slot_pat_ok;
		logic       slot_ply_ok;
		logic       qpat_used;
		logic       div_last;
	} sfs_stat_t;
endpackage
`default_nettype wire

// ----- src/sfs_ctrl.sv -----
// Controller state machine of the sprite frame sequencer.
// Depends on sfs_pkg; drives sfs_datapath through command and status structs.
`default_nettype none
module sfs_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output sfs_pkg::sfs_cmd_t     cmd,
	input  wire sfs_pkg::sfs_stat_t st
);
	import sfs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_T_CHK, S_T_PAT, S_T_CMP, S_T_WR, S_R_SCAN, S_C_SCAN,
		S_Q_PLY, S_Q_PAT, S_Q_DIV, S_Q_MUL, S_EMIT
	} state_t;

	state_t    state_q;
	res_kind_t kind_q;
	logic      fire;

	assign fire = (state_q == S_EMIT) && (!out_valid || out_ready);

	always_comb begin
		cmd = '0;
		cmd.kind = kind_q;
		cmd.emit = fire;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				cmd.idx_clr = in_valid;
			end
			S_DISPATCH: begin
				cmd.ply_free    = (st.op == OP_DESTROY) && st.slot_ply_ok;
				cmd.ply_rd_slot = (st.op == OP_QUERY) && st.slot_ply_ok;
			end
			S_T_CHK: begin
				cmd.ply_rd_idx = !st.ply_scan_end && st.ply_idx_used;
				cmd.idx_inc    = !st.ply_scan_end && !st.ply_idx_used;
			end
			S_T_PAT: cmd.pat_rd = 1'b1;
			S_T_CMP: cmd.tick_cmp = 1'b1;
			S_T_WR: begin
				cmd.tick_wr = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			S_R_SCAN: begin
				cmd.pat_claim = !st.pat_scan_end && !st.pat_idx_used;
				cmd.idx_inc   = !st.pat_scan_end && st.pat_idx_used;
			end
			S_C_SCAN: begin
				cmd.ply_claim = !st.ply_scan_end && !st.ply_idx_used;
				cmd.idx_inc   = !st.ply_scan_end && st.ply_idx_used;
			end
			S_Q_PLY: cmd.pat_rd = 1'b1;
			S_Q_PAT: cmd.div_start = st.qpat_used;
			S_Q_DIV: cmd.div_step = 1'b1;
			S_Q_MUL: cmd.q_mul = 1'b1;
			S_EMIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kind_q    <= RES_NONE;
			out_valid <= 1'b0;
		end else begin
			if (fire)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					unique case (st.op)
						OP_TICK: state_q <= S_T_CHK;
						OP_REGISTER: state_q <= S_R_SCAN;
						OP_CREATE: begin
							if (st.slot_pat_ok) begin
								state_q <= S_C_SCAN;
							end else begin
								kind_q  <= RES_UNUSED;
								state_q <= S_EMIT;
							end
						end
						OP_DESTROY: begin
							kind_q  <= st.slot_ply_ok ? RES_NONE : RES_UNUSED;
							state_q <= S_EMIT;
						end
						OP_QUERY: begin
							if (st.slot_ply_ok) begin
								state_q <= S_Q_PLY;
							end else begin
								kind_q  <= RES_UNUSED;
								state_q <= S_EMIT;
							end
						end
						default: begin
							kind_q  <= RES_NONE;
							state_q <= S_EMIT;
						end
					endcase
				end
				S_T_CHK: begin
					if (st.ply_scan_end) begin
						kind_q  <= RES_NONE;
						state_q <= S_EMIT;
					end else if (st.ply_idx_used) begin
						state_q <= S_T_PAT;
					end
				end
				S_T_PAT: state_q <= S_T_CMP;
				S_T_CMP: state_q <= S_T_WR;
				S_T_WR: state_q <= S_T_CHK;
				S_R_SCAN, S_C_SCAN: begin
					if (st.pat_scan_end && state_q == S_R_SCAN) begin
						kind_q  <= RES_FULL;
						state_q <= S_EMIT;
					end else if (st.ply_scan_end && state_q == S_C_SCAN) begin
						kind_q  <= RES_FULL;
						state_q <= S_EMIT;
					end else if ((state_q == S_R_SCAN && !st.pat_idx_used)
							|| (state_q == S_C_SCAN && !st.ply_idx_used)) begin
						kind_q  <= RES_GRANT;
						state_q <= S_EMIT;
					end
				end
				S_Q_PLY: state_q <= S_Q_PAT;
				S_Q_PAT: begin
					if (st.qpat_used) begin
						state_q <= S_Q_DIV;
					end else begin
						kind_q  <= RES_UNUSED;
						state_q <= S_EMIT;
					end
				end
				S_Q_DIV: if (st.div_last) state_q <= S_Q_MUL;
				S_Q_MUL: begin
					kind_q  <= RES_QUERY;
					state_q <= S_EMIT;
				end
				S_EMIT: if (fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/sfs_datapath.sv -----
// Datapath of the sprite frame sequencer: pattern and player memories,
// slot flags, scan counter, tick arithmetic, frame divider and result register.
// Depends on sfs_pkg.
`default_nettype none
module sfs_datapath #(
	parameter int PATTERN_SLOTS = 128,
	parameter int PLAYER_SLOTS  = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfs_pkg::sfs_cmd_t cmd,
	output sfs_pkg::sfs_stat_t     st,
	input  wire logic [2:0]        operation,
	input  wire logic [23:0]       elapsed_us,
	input  wire logic [9:0]        texture_number,
	input  wire logic [8:0]        frame_total,
	input  wire logic [8:0]        frames_across,
	input  wire logic [23:0]       frame_period_us,
	input  wire logic [11:0]       frame_width,
	input  wire logic [11:0]       frame_height,
	input  wire logic [11:0]       sheet_origin_x,
	input  wire logic [11:0]       sheet_origin_y,
	input  wire logic              repeat_mode,
	input  wire logic [7:0]        target_slot,
	output logic [1:0]             status,
	output logic [7:0]             granted_slot,
	output logic [9:0]             texture_out,
	output logic [19:0]            source_x,
	output logic [19:0]            source_y,
	output logic [11:0]            source_width,
	output logic [11:0]            source_height,
	output logic                   halted
);
	import sfs_pkg::*;

	localparam int PIW  = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
	localparam int PLW  = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
	localparam int MAXS = (PATTERN_SLOTS > PLAYER_SLOTS) ? PATTERN_SLOTS : PLAYER_SLOTS;
	localparam int IW   = $clog2(MAXS + 1) + 1;

	logic [2:0]       op_q;
	logic [23:0]      elapsed_q;
	logic [7:0]       slot_q;
	pattern_t         new_pat_q;
	logic [IW-1:0]    idx_q;

	pattern_t         pat_mem [PATTERN_SLOTS];
	player_t          ply_mem [PLAYER_SLOTS];
	pattern_t         pat_rd_q;
	player_t          ply_rd_q;
	logic             pat_used_q [PATTERN_SLOTS];
	logic             ply_used_q [PLAYER_SLOTS];
	logic             ply_halt_q [PLAYER_SLOTS];

	logic [31:0]      acc_s1;
	logic [7:0]       frame_s1;
	logic             halt_s1;
	logic [8:0]       rem_q;
	logic [7:0]       quo_q;
	logic [2:0]       dcnt_q;
	logic [19:0]      prod_x_q;
	logic [19:0]      prod_y_q;

	logic [PIW-1:0]   pat_idx;
	logic [PLW-1:0]   ply_idx;
	logic [PIW+7:0]   slot_pat_ext;
	logic [PLW+7:0]   slot_ply_ext;
	logic [PIW+7:0]   qpat_ext;
	logic [IW+7:0]    grant_ext;
	logic [PIW-1:0]   slot_pat;
	logic [PLW-1:0]   slot_ply;
	logic [PIW-1:0]   qpat_idx;
	logic [PLW-1:0]   ply_rd_addr;

	logic [31:0]      period32;
	logic             adv;
	logic [8:0]       tot9;
	logic [8:0]       f9;
	logic             wrap;
	logic [7:0]       next_frame;
	logic [32:0]      sum33;
	logic [31:0]      acc_sat;
	logic [8:0]       across_eff;
	logic [8:0]       trial;
	logic             ge;
	logic             res_query;

	assign pat_idx      = idx_q[PIW-1:0];
	assign ply_idx      = idx_q[PLW-1:0];
	assign slot_pat_ext = {{PIW{1'b0}}, slot_q};
	assign slot_ply_ext = {{PLW{1'b0}}, slot_q};
	assign qpat_ext     = {{PIW{1'b0}}, ply_rd_q.pattern};
	assign grant_ext    = {8'd0, idx_q};
	assign slot_pat     = slot_pat_ext[PIW-1:0];
	assign slot_ply     = slot_ply_ext[PLW-1:0];
	assign qpat_idx     = qpat_ext[PIW-1:0];
	assign ply_rd_addr  = cmd.ply_rd_slot ? slot_ply : ply_idx;
	assign res_query    = (cmd.kind == RES_QUERY);

	always_comb begin
		st.op           = op_q;
		st.pat_scan_end = (idx_q == IW'(PATTERN_SLOTS));
		st.ply_scan_end = (idx_q == IW'(PLAYER_SLOTS));
		st.pat_idx_used = pat_used_q[pat_idx];
		st.ply_idx_used = ply_used_q[ply_idx];
		st.slot_pat_ok  = ({3'd0, slot_q} < 11'(PATTERN_SLOTS)) && pat_used_q[slot_pat];
		st.slot_ply_ok  = ({3'd0, slot_q} < 11'(PLAYER_SLOTS)) && ply_used_q[slot_ply];
		st.qpat_used    = pat_used_q[qpat_idx];
		st.div_last     = (dcnt_q == 3'd7);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q              <= operation;
			elapsed_q         <= elapsed_us;
			slot_q            <= target_slot;
			new_pat_q.texture <= texture_number;
			new_pat_q.total   <= frame_total;
			new_pat_q.across  <= frames_across;
			new_pat_q.period  <= frame_period_us;
			new_pat_q.width   <= frame_width;
			new_pat_q.height  <= frame_height;
			new_pat_q.org_x   <= sheet_origin_x;
			new_pat_q.org_y   <= sheet_origin_y;
			new_pat_q.repeats <= repeat_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pat_claim)
			pat_mem[pat_idx] <= new_pat_q;
		if (cmd.pat_rd)
			pat_rd_q <= pat_mem[qpat_idx];
	end

	always_comb begin
		sum33   = {1'b0, acc_s1} + {9'd0, elapsed_q};
		acc_sat = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.ply_claim)
			ply_mem[ply_idx] <= '{pattern: slot_q, frame: 8'd0, acc: 32'd0};
		else if (cmd.tick_wr)
			ply_mem[ply_idx] <= '{pattern: ply_rd_q.pattern, frame: frame_s1, acc: acc_sat};
		if (cmd.ply_rd_idx || cmd.ply_rd_slot)
			ply_rd_q <= ply_mem[ply_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_SLOTS; i++)
				pat_used_q[i] <= 1'b0;
			for (int i = 0; i < PLAYER_SLOTS; i++) begin
				ply_used_q[i] <= 1'b0;
				ply_halt_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.pat_claim)
				pat_used_q[pat_idx] <= 1'b1;
			if (cmd.ply_claim) begin
				ply_used_q[ply_idx] <= 1'b1;
				ply_halt_q[ply_idx] <= 1'b0;
			end
			if (cmd.ply_free)
				ply_used_q[slot_ply] <= 1'b0;
			if (cmd.tick_wr && halt_s1)
				ply_halt_q[ply_idx] <= 1'b1;
		end
	end

	always_comb begin
		period32 = {8'd0, pat_rd_q.period};
		adv      = (ply_rd_q.acc >= period32);
		if (pat_rd_q.total == 9'd0)
			tot9 = 9'd1;
		else if (pat_rd_q.total > 9'd256)
			tot9 = 9'd256;
		else
			tot9 = pat_rd_q.total;
		f9   = {1'b0, ply_rd_q.frame} + 9'd1;
		wrap = (f9 >= tot9);
		if (!adv)
			next_frame = ply_rd_q.frame;
		else if (!wrap)
			next_frame = f9[7:0];
		else if (pat_rd_q.repeats)
			next_frame = 8'd0;
		else
			next_frame = 8'(tot9 - 9'd1);
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_cmp) begin
			acc_s1   <= adv ? (ply_rd_q.acc - period32) : ply_rd_q.acc;
			frame_s1 <= next_frame;
			halt_s1  <= adv && wrap && !pat_rd_q.repeats;
		end
	end

	always_comb begin
		across_eff = (pat_rd_q.across == 9'd0) ? 9'd1 : pat_rd_q.across;
		trial      = {rem_q[7:0], quo_q[7]};
		ge         = (trial >= across_eff);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q  <= 9'd0;
			quo_q  <= ply_rd_q.frame;
			dcnt_q <= 3'd0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? (trial - across_eff) : trial;
			quo_q  <= {quo_q[6:0], ge};
			dcnt_q <= dcnt_q + 3'd1;
		end
		if (cmd.q_mul) begin
			prod_x_q <= {8'd0, pat_rd_q.width} * {12'd0, rem_q[7:0]};
			prod_y_q <= {8'd0, pat_rd_q.height} * {12'd0, quo_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status        <= (cmd.kind == RES_FULL) ? STATUS_FULL :
				(cmd.kind == RES_UNUSED) ? STATUS_UNUSED : STATUS_OK;
			granted_slot  <= (cmd.kind == RES_GRANT) ? grant_ext[7:0] : 8'd0;
			texture_out   <= res_query ? pat_rd_q.texture : 10'd0;
			source_x      <= res_query ? ({8'd0, pat_rd_q.org_x} + prod_x_q) : 20'd0;
			source_y      <= res_query ? ({8'd0, pat_rd_q.org_y} + prod_y_q) : 20'd0;
			source_width  <= res_query ? pat_rd_q.width : 12'd0;
			source_height <= res_query ? pat_rd_q.height : 12'd0;
			halted        <= res_query ? ply_halt_q[slot_ply] : 1'b0;
		end
	end
endmodule
`default_nettype wire

// ----- src/sprite_frame_sequencer.sv -----
// Top level of the sprite frame sequencer: controller plus datapath.
// Depends on sfs_pkg, sfs_ctrl and sfs_datapath.
//
//  channel  handshake            payload
//  in       in_valid / in_ready  operation .. target_slot
//  out      out_valid/ out_ready status .. last
//
// One item at a time. Tick: walks the single-port player memory, skipping each
// free slot and reading, updating and writing back each active one. Register and
// create scan up to the first free slot. Query: runs the 8-step frame divider.
// All flags clear at once on reset; no clearing pass. A waiting result holds in
// the output register while the next item is taken.
`default_nettype none
module sprite_frame_sequencer #(
	parameter int PATTERN_SLOTS = 128,
	parameter int PLAYER_SLOTS  = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic [23:0] elapsed_us,
	input  wire logic [9:0]  texture_number,
	input  wire logic [8:0]  frame_total,
	input  wire logic [8:0]  frames_across,
	input  wire logic [23:0] frame_period_us,
	input  wire logic [11:0] frame_width,
	input  wire logic [11:0] frame_height,
	input  wire logic [11:0] sheet_origin_x,
	input  wire logic [11:0] sheet_origin_y,
	input  wire logic        repeat_mode,
	input  wire logic [7:0]  target_slot,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [7:0]       granted_slot,
	output logic [9:0]       texture_out,
	output logic [19:0]      source_x,
	output logic [19:0]      source_y,
	output logic [11:0]      source_width,
	output logic [11:0]      source_height,
	output logic             halted,
	output logic             last
);
	import sfs_pkg::*;

	sfs_cmd_t  cmd;
	sfs_stat_t st;

	assign last = 1'b1;

	sfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

	sfs_datapath #(
		.PATTERN_SLOTS (PATTERN_SLOTS),
		.PLAYER_SLOTS  (PLAYER_SLOTS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.operation       (operation),
		.elapsed_us      (elapsed_us),
		.texture_number  (texture_number),
		.frame_total     (frame_total),
		.frames_across   (frames_across),
		.frame_period_us (frame_period_us),
		.frame_width     (frame_width),
		.frame_height    (frame_height),
		.sheet_origin_x  (sheet_origin_x),
		.sheet_origin_y  (sheet_origin_y),
		.repeat_mode     (repeat_mode),
		.target_slot     (target_slot),
		.status          (status),
		.granted_slot    (granted_slot),
		.texture_out     (texture_out),
		.source_x        (source_x),
		.source_y        (source_y),
		.source_width    (source_width),
		.source_height   (source_height),
		.halted          (halted)
	);
endmodule
`default_nettype wire

// ----- src/sfs_checker.sv -----
// Port-level checks of the sprite frame sequencer, bound to the top level.
// Depends on sfs_pkg and sprite_frame_sequencer_defines.svh.
`default_nettype none
module sfs_port_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] status,
	input wire logic [7:0] granted_slot,
	input wire logic [9:0] texture_out,
	input wire logic       halted,
	input wire logic       last
);
	import sfs_pkg::*;
`include "sprite_frame_sequencer_defines.svh"

	`SFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`SFS_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
	`SFS_ASSERT_SAME(a_last_set, out_valid, last)
	`SFS_ASSERT_SAME(a_fail_clear, out_valid && status != STATUS_OK, granted_slot == 8'd0 && texture_out == 10'd0 && !halted)
endmodule

bind sprite_frame_sequencer sfs_port_checker u_sfs_checker (.*);
`default_nettype wire
